[rtl/iomb_pkg.sv]
// Shared types, constants and codes of the ignition offset map blend block.
package iomb_pkg;

   localparam int CURVE_POINTS = 17;
   localparam int CURVE_STEP   = 100;
   localparam int AXIS_POINTS  = 8;
   localparam int FACTOR_ONE   = 256;
   localparam int HARD_MAX     = 16;

   localparam int IDX_SPEED = CURVE_POINTS;
   localparam int IDX_LOAD  = CURVE_POINTS + AXIS_POINTS;
   localparam int IDX_MAP   = CURVE_POINTS + 2 * AXIS_POINTS;
   localparam int IDX_END   = IDX_MAP + AXIS_POINTS * AXIS_POINTS;

   localparam int RAM_AW   = $clog2(IDX_END);
   localparam int RAM_W    = 16;
   localparam int CIDX_W   = $clog2(CURVE_POINTS);
   localparam int AXW      = $clog2(AXIS_POINTS);
   localparam int FR_W     = $clog2(CURVE_STEP);
   localparam int CPROD_W  = FR_W + 10;
   localparam int RSHIFT   = 24;
   localparam int RECIP    = (2 ** RSHIFT + CURVE_STEP - 1) / CURVE_STEP;
   localparam int RECIP_W  = RSHIFT + 1;
   localparam int FSHIFT   = $clog2(FACTOR_ONE);
   localparam int FRAC_W   = 16;
   localparam int DCNT_W   = $clog2(FRAC_W);
   localparam int ETH_W    = 12;

   localparam logic       CMD_LOAD      = 1'b0;
   localparam logic       CMD_COMPUTE   = 1'b1;
   localparam logic [2:0] MODE_OVERRIDE = 3'd2;
   localparam logic       CSR_ENABLE    = 1'b0;
   localparam logic       CSR_CEILING   = 1'b1;

   typedef struct packed {
      logic        command;
      logic [6:0]  table_index;
      logic [15:0] table_value;
      logic        calibration_valid;
      logic [2:0]  operating_mode;
      logic [11:0] filtered_ethanol;
      logic [15:0] engine_speed;
      logic [15:0] engine_load;
   } req_type;

   typedef struct packed {
      logic [8:0]        blend_factor;
      logic signed [7:0] advance_offset;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_START, OP_ZERO, OP_CURVE_A, OP_CURVE_B, OP_CURVE_C, OP_CURVE_D,
      OP_AXIS_RD, OP_AXIS_END, OP_DIV, OP_MAP_A, OP_MAP_B, OP_MAP_C, OP_MAP_D,
      OP_MAP_E, OP_MAP_F, OP_MUL, OP_ROUND, OP_EMIT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_START, ST_ZERO, ST_CURVE_A, ST_CURVE_B, ST_CURVE_C, ST_CURVE_D,
      ST_AXIS_RD, ST_AXIS_END, ST_DIV, ST_MAP_A, ST_MAP_B, ST_MAP_C, ST_MAP_D,
      ST_MAP_E, ST_MAP_F, ST_MUL, ST_ROUND, ST_DONE
   } state_type;

   typedef struct packed {
      op_type op;
      logic   accept;
   } cmd_type;

   typedef struct packed {
      logic zero_force;
      logic scan_last;
      logic div_done;
      logic axis_sel;
   } status_type;

endpackage

[rtl/iomb_ram.sv]
// Generic single-write, single-read memory with registered read data.
module iomb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 97
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/iomb_datapath.sv]
// Datapath: table memory, curve and map arithmetic, axis search and shared divider.
module iomb_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  iomb_pkg::cmd_type    cmd,
   input  iomb_pkg::req_type    req_data,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [7:0]           csr_wdata,
   output iomb_pkg::status_type status,
   output iomb_pkg::rsp_type    rsp_data
);
   import iomb_pkg::*;

   function automatic logic signed [9:0] lerp_fn(input logic signed [9:0] lo,
                                                 input logic signed [9:0] hi,
                                                 input logic [15:0] f);
      logic signed [10:0] diff;
      logic signed [27:0] prod;
      logic signed [27:0] sh;
      logic signed [10:0] sum;
      diff = 11'(hi) - 11'(lo);
      prod = 28'(signed'({1'b0, f})) * 28'(diff);
      sh   = prod >>> 16;
      sum  = 11'(lo) + sh[10:0];
      return sum[9:0];
   endfunction

   req_type              req_ff;
   logic                 en_ff, en_in;
   logic [7:0]           ceil_ff, ceil_in;
   logic [CIDX_W-1:0]    seg_ff, seg_in;
   logic                 high_ff, high_in;
   logic [FR_W-1:0]      fr_ff, fr_in;
   logic [7:0]           a_ff, a_in;
   logic signed [CPROD_W-1:0] cprod_ff, cprod_in;
   logic [8:0]           blend_ff, blend_in;
   logic [AXW-1:0]       cnt_ff, cnt_in;
   logic                 sel_ff, sel_in;
   logic                 found_ff, found_in;
   logic [15:0]          first_ff, first_in;
   logic [15:0]          prev_ff, prev_in;
   logic [15:0]          lo_ff, lo_in;
   logic [15:0]          hi_ff, hi_in;
   logic [AXW-1:0]       segi_ff, segi_in;
   logic [AXW-1:0]       cy_ff, cy_in;
   logic [AXW-1:0]       cx_ff, cx_in;
   logic [FRAC_W-1:0]    fy_ff, fy_in;
   logic [FRAC_W-1:0]    fx_ff, fx_in;
   logic                 go_ff, go_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          dvs_ff, dvs_in;
   logic [DCNT_W-1:0]    dcnt_ff, dcnt_in;
   logic signed [9:0]    m00_ff, m00_in;
   logic signed [9:0]    m10_ff, m10_in;
   logic signed [9:0]    vt_ff, vt_in;
   logic signed [9:0]    vb_ff, vb_in;
   logic signed [7:0]    d_ff, d_in;
   logic signed [17:0]   oprod_ff, oprod_in;
   logic signed [7:0]    off_ff, off_in;
   rsp_type              rsp_ff, rsp_in;

   logic [RAM_AW-1:0]    rd_addr;
   logic [RAM_W-1:0]     rd_data;
   logic                 wr_en;
   logic [RAM_AW-1:0]    map_base;
   logic [15:0]          v;
   logic                 proc;
   logic [AXW-1:0]       jdx;
   logic                 div_done;
   logic [16:0]          dshift;
   logic                 dge;
   logic [16:0]          dsub;
   logic [ETH_W+RECIP_W-1:0] eprod;
   logic [ETH_W-1:0]     eseg;
   logic [CPROD_W-1:0]   cmag;
   logic [CPROD_W+RECIP_W-1:0] cq;
   logic signed [CPROD_W:0] fsum;
   logic [17:0]          omag;
   logic [17:0]          oq;
   logic [7:0]           ocap;
   logic [7:0]           olim;
   logic signed [9:0]    rd_s;
   logic signed [9:0]    vf;

   assign wr_en = cmd.accept && (req_data.command == CMD_LOAD)
                  && (req_data.table_index < 7'(IDX_END));

   iomb_ram #(.WIDTH(RAM_W), .DEPTH(IDX_END)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_data.table_index[RAM_AW-1:0]),
      .wr_data (req_data.table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign map_base = RAM_AW'(IDX_MAP) + RAM_AW'(cx_ff) + RAM_AW'(AXIS_POINTS * cy_ff);
   assign v        = sel_ff ? req_ff.engine_load : req_ff.engine_speed;
   assign rd_s     = 10'(signed'(rd_data[7:0]));
   assign div_done = !go_ff || (dcnt_ff == DCNT_W'(FRAC_W - 1));

   always_comb begin
      unique case (cmd.op)
         OP_CURVE_A: rd_addr = RAM_AW'(seg_ff);
         OP_CURVE_B: rd_addr = high_ff ? RAM_AW'(seg_ff) : RAM_AW'(seg_ff) + RAM_AW'(1);
         OP_AXIS_RD: rd_addr = (sel_ff ? RAM_AW'(IDX_LOAD) : RAM_AW'(IDX_SPEED))
                               + RAM_AW'(cnt_ff);
         OP_MAP_A:   rd_addr = map_base;
         OP_MAP_B:   rd_addr = (fx_ff != '0) ? map_base + RAM_AW'(1) : map_base;
         OP_MAP_C:   rd_addr = (fy_ff != '0) ? map_base + RAM_AW'(AXIS_POINTS) : map_base;
         OP_MAP_D:   rd_addr = (fx_ff != '0 && fy_ff != '0)
                               ? map_base + RAM_AW'(AXIS_POINTS + 1) : map_base;
         default:    rd_addr = '0;
      endcase
   end

   always_comb begin
      eprod  = ETH_W'(req_ff.filtered_ethanol) * RECIP_W'(RECIP);
      eseg   = ETH_W'(eprod >> RSHIFT);
      cmag   = cprod_ff[CPROD_W-1] ? CPROD_W'(-cprod_ff) : CPROD_W'(cprod_ff);
      cq     = (CPROD_W + RECIP_W)'(cmag) * (CPROD_W + RECIP_W)'(RECIP);
      fsum   = cprod_ff[CPROD_W-1]
               ? (CPROD_W + 1)'(a_ff) - (CPROD_W + 1)'(cq >> RSHIFT)
               : (CPROD_W + 1)'(a_ff) + (CPROD_W + 1)'(cq >> RSHIFT);
      proc   = (cmd.op == OP_AXIS_RD && cnt_ff != '0) || cmd.op == OP_AXIS_END;
      jdx    = (cmd.op == OP_AXIS_END) ? AXW'(AXIS_POINTS - 1) : cnt_ff - AXW'(1);
      dshift = {rem_ff, 1'b0};
      dge    = dshift >= {1'b0, dvs_ff};
      dsub   = dshift - {1'b0, dvs_ff};
      vf     = (fy_ff != '0) ? lerp_fn(vt_ff, vb_ff, fy_ff) : vt_ff;
      omag   = oprod_ff[17] ? 18'(-oprod_ff) : 18'(oprod_ff);
      oq     = (omag + 18'(FACTOR_ONE / 2)) >> FSHIFT;
      ocap   = (ceil_ff > 8'(HARD_MAX)) ? 8'(HARD_MAX) : ceil_ff;
      olim   = (oq > 18'(ocap)) ? ocap : oq[7:0];
   end

   always_comb begin
      en_in    = en_ff;
      ceil_in  = ceil_ff;
      seg_in   = seg_ff;
      high_in  = high_ff;
      fr_in    = fr_ff;
      a_in     = a_ff;
      cprod_in = cprod_ff;
      blend_in = blend_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      found_in = found_ff;
      first_in = first_ff;
      prev_in  = prev_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      segi_in  = segi_ff;
      cy_in    = cy_ff;
      cx_in    = cx_ff;
      fy_in    = fy_ff;
      fx_in    = fx_ff;
      go_in    = go_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      dcnt_in  = dcnt_ff;
      m00_in   = m00_ff;
      m10_in   = m10_ff;
      vt_in    = vt_ff;
      vb_in    = vb_ff;
      d_in     = d_ff;
      oprod_in = oprod_ff;
      off_in   = off_ff;
      rsp_in   = rsp_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_ENABLE:  en_in   = csr_wdata[0];
            CSR_CEILING: ceil_in = csr_wdata;
            default:     ;
         endcase
      end

      if (proc) begin
         prev_in = rd_data;
         if (jdx == '0) begin
            first_in = rd_data;
         end else if (!found_ff && v >= prev_ff && v < rd_data && rd_data > prev_ff) begin
            found_in = 1'b1;
            segi_in  = jdx - AXW'(1);
            lo_in    = prev_ff;
            hi_in    = rd_data;
         end
      end

      unique case (cmd.op)
         OP_START: begin
            high_in  = 32'(req_ff.filtered_ethanol) >= (CURVE_POINTS - 1) * CURVE_STEP;
            seg_in   = high_in ? CIDX_W'(CURVE_POINTS - 1) : eseg[CIDX_W-1:0];
            cnt_in   = '0;
            sel_in   = 1'b0;
            found_in = 1'b0;
            go_in    = 1'b0;
         end
         OP_ZERO: begin
            blend_in = '0;
            off_in   = '0;
         end
         OP_CURVE_A: begin
            fr_in = FR_W'(req_ff.filtered_ethanol - ETH_W'(seg_ff) * ETH_W'(CURVE_STEP));
         end
         OP_CURVE_B: begin
            a_in = rd_data[7:0];
         end
         OP_CURVE_C: begin
            cprod_in = CPROD_W'(signed'({2'b00, rd_data[7:0]}) - signed'({2'b00, a_ff}))
                       * CPROD_W'(signed'({1'b0, fr_ff}));
         end
         OP_CURVE_D: begin
            if (high_ff) begin
               blend_in = (9'(a_ff) > 9'(FACTOR_ONE)) ? 9'(FACTOR_ONE) : 9'(a_ff);
            end else if (fsum < 0) begin
               blend_in = '0;
            end else if (fsum > (CPROD_W + 1)'(FACTOR_ONE)) begin
               blend_in = 9'(FACTOR_ONE);
            end else begin
               blend_in = 9'(fsum);
            end
         end
         OP_AXIS_RD: begin
            cnt_in = cnt_ff + AXW'(1);
         end
         OP_AXIS_END: begin
            dcnt_in = '0;
            go_in   = 1'b0;
            if (sel_ff) fx_in = '0; else fy_in = '0;
            if (v <= first_ff) begin
               if (sel_ff) cx_in = '0; else cy_in = '0;
            end else if (v >= rd_data) begin
               if (sel_ff) cx_in = AXW'(AXIS_POINTS - 1); else cy_in = AXW'(AXIS_POINTS - 1);
            end else if (found_in) begin
               if (sel_ff) cx_in = segi_in; else cy_in = segi_in;
               go_in  = 1'b1;
               rem_in = v - lo_in;
               dvs_in = hi_in - lo_in;
            end else begin
               if (sel_ff) cx_in = '0; else cy_in = '0;
            end
         end
         OP_DIV: begin
            if (go_ff) begin
               rem_in  = dge ? dsub[15:0] : dshift[15:0];
               dcnt_in = dcnt_ff + DCNT_W'(1);
               if (sel_ff) fx_in = {fx_ff[FRAC_W-2:0], dge};
               else        fy_in = {fy_ff[FRAC_W-2:0], dge};
            end
            if (div_done) begin
               sel_in   = !sel_ff;
               cnt_in   = '0;
               found_in = 1'b0;
               go_in    = 1'b0;
            end
         end
         OP_MAP_B: begin
            m00_in = rd_s;
         end
         OP_MAP_C: begin
            vt_in = (fx_ff != '0) ? lerp_fn(m00_ff, rd_s, fx_ff) : m00_ff;
         end
         OP_MAP_D: begin
            m10_in = rd_s;
         end
         OP_MAP_E: begin
            vb_in = (fx_ff != '0) ? lerp_fn(m10_ff, rd_s, fx_ff) : m10_ff;
         end
         OP_MAP_F: begin
            d_in = vf[7:0];
         end
         OP_MUL: begin
            oprod_in = 18'(signed'({1'b0, blend_ff})) * 18'(d_ff);
         end
         OP_ROUND: begin
            off_in = oprod_ff[17] ? -signed'(olim) : signed'(olim);
         end
         OP_EMIT: begin
            rsp_in.blend_factor   = blend_ff;
            rsp_in.advance_offset = off_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         ceil_ff  <= '0;
         cnt_ff   <= '0;
         sel_ff   <= 1'b0;
         found_ff <= 1'b0;
         go_ff    <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         en_ff    <= en_in;
         ceil_ff  <= ceil_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         found_ff <= found_in;
         go_ff    <= go_in;
         dcnt_ff  <= dcnt_in;
      end
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      seg_ff   <= seg_in;
      high_ff  <= high_in;
      fr_ff    <= fr_in;
      a_ff     <= a_in;
      cprod_ff <= cprod_in;
      blend_ff <= blend_in;
      first_ff <= first_in;
      prev_ff  <= prev_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      segi_ff  <= segi_in;
      cy_ff    <= cy_in;
      cx_ff    <= cx_in;
      fy_ff    <= fy_in;
      fx_ff    <= fx_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      m00_ff   <= m00_in;
      m10_ff   <= m10_in;
      vt_ff    <= vt_in;
      vb_ff    <= vb_in;
      d_ff     <= d_in;
      oprod_ff <= oprod_in;
      off_ff   <= off_in;
      rsp_ff   <= rsp_in;
   end

   assign status.zero_force = !en_ff || !req_ff.calibration_valid
                              || (req_ff.filtered_ethanol == '0)
                              || (req_ff.operating_mode > MODE_OVERRIDE);
   assign status.scan_last  = (cnt_ff == AXW'(AXIS_POINTS - 1));
   assign status.div_done   = div_done;
   assign status.axis_sel   = sel_ff;
   assign rsp_data          = rsp_ff;
endmodule

[rtl/iomb_ctrl.sv]
// Controller: sequences each request through the datapath and owns the handshakes.
module iomb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  iomb_pkg::status_type status,
   output iomb_pkg::cmd_type    cmd
);
   import iomb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid && req_command == CMD_COMPUTE) state_in = ST_START;
         ST_START:    state_in = status.zero_force ? ST_ZERO : ST_CURVE_A;
         ST_ZERO:     state_in = ST_DONE;
         ST_CURVE_A:  state_in = ST_CURVE_B;
         ST_CURVE_B:  state_in = ST_CURVE_C;
         ST_CURVE_C:  state_in = ST_CURVE_D;
         ST_CURVE_D:  state_in = ST_AXIS_RD;
         ST_AXIS_RD:  if (status.scan_last) state_in = ST_AXIS_END;
         ST_AXIS_END: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_done) state_in = status.axis_sel ? ST_MAP_A : ST_AXIS_RD;
         end
         ST_MAP_A:    state_in = ST_MAP_B;
         ST_MAP_B:    state_in = ST_MAP_C;
         ST_MAP_C:    state_in = ST_MAP_D;
         ST_MAP_D:    state_in = ST_MAP_E;
         ST_MAP_E:    state_in = ST_MAP_F;
         ST_MAP_F:    state_in = ST_MUL;
         ST_MUL:      state_in = ST_ROUND;
         ST_ROUND:    state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      req_stall    = (state_ff != ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_START:    cmd.op = OP_START;
         ST_ZERO:     cmd.op = OP_ZERO;
         ST_CURVE_A:  cmd.op = OP_CURVE_A;
         ST_CURVE_B:  cmd.op = OP_CURVE_B;
         ST_CURVE_C:  cmd.op = OP_CURVE_C;
         ST_CURVE_D:  cmd.op = OP_CURVE_D;
         ST_AXIS_RD:  cmd.op = OP_AXIS_RD;
         ST_AXIS_END: cmd.op = OP_AXIS_END;
         ST_DIV:      cmd.op = OP_DIV;
         ST_MAP_A:    cmd.op = OP_MAP_A;
         ST_MAP_B:    cmd.op = OP_MAP_B;
         ST_MAP_C:    cmd.op = OP_MAP_C;
         ST_MAP_D:    cmd.op = OP_MAP_D;
         ST_MAP_E:    cmd.op = OP_MAP_E;
         ST_MAP_F:    cmd.op = OP_MAP_F;
         ST_MUL:      cmd.op = OP_MUL;
         ST_ROUND:    cmd.op = OP_ROUND;
         ST_DONE: begin
            cmd.op = out_free ? OP_EMIT : OP_NONE;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> out_free)
      else $error("result issued while the output register was occupied");
   a_compute_start: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && req_command == CMD_COMPUTE |=> state_ff == ST_START)
      else $error("accepted compute request did not start");
   a_axis_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AXIS_END |=> state_ff == ST_DIV)
      else $error("axis search did not hand over to the divider");
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result appeared outside the completion step");
endmodule

[rtl/ignition_offset_map_blend.sv]
// Top level of the ignition offset map blend block.
//
// Requests arrive on req_valid/req_stall with a req_type payload. A load
// request writes one calibration table entry in the cycle it is accepted and
// produces no result. A compute request produces one result on
// rsp_valid/rsp_stall carrying the blend factor and the advance offset.
// One request is worked on at a time; req_stall is low only while idle, so
// the next request can be taken in the cycle after a result is issued.
// A compute request not forced to zero runs through the two axis scans
// (eight table reads each) and the bit-serial 16-step fraction divider,
// which runs once per axis when the value falls inside a segment. The
// result waits in an output register, so a new request is accepted while
// a stalled result is still held; the block waits only if it finishes
// again before that result is taken. Reset clears the control state and
// the two configuration registers; the tables are undefined until loaded.
// Configuration is written through csr_write/csr_index/csr_wdata; the user
// must do so only while idle, as the block itself does not enforce it.
module ignition_offset_map_blend (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iomb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iomb_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);
   import iomb_pkg::*;

   cmd_type    cmd;
   status_type status;

   iomb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   iomb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );
endmodule
